// ===== rtl/sic_pkg.sv =====
// Shared types and constants for the subset indicator correlation block.
package sic_pkg;

    localparam int VAL_W  = 13;
    localparam int CORR_W = 32;
    localparam int FRAC_W = 30;

    localparam logic MODE_A = 1'b0;
    localparam logic MODE_B = 1'b1;

    // Input beat payload
    typedef struct packed {
        logic             mode;
        logic [VAL_W-1:0] value;
        logic             last;
    } t_in_item;

    // Result beat payload
    typedef struct packed {
        logic signed [CORR_W-1:0] correlation;
        logic [VAL_W-1:0]         common_count;
        logic                     degenerate;
    } t_out_item;

    // Job handed from the merge engine to the arithmetic engine
    typedef struct packed {
        logic [VAL_W-1:0] nn;
        logic [16:0]      m;
        logic [16:0]      n;
        logic [16:0]      c;
    } t_job;

endpackage

// ===== rtl/sic_if.sv =====
// Valid/ready channel interfaces for input, result and configuration beats.
interface sic_in_if;
    import sic_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sic_out_if;
    import sic_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sic_cfg_if;
    logic        valid;
    logic        ready;
    logic [12:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/subset_indicator_correlation.sv =====
// Top level: merge front end, one-entry job queue, arithmetic back end.
// An A beat is stored as it is accepted. A B beat runs the merge pointer: one memory read
// and one compare per pointer step over the skipped A elements; the last B beat emits a job.
// The back end forms the products, then runs a 31-step bitwise search before the result
// is registered; the search is skipped when degenerate or when the difference is zero.
// The merge front end takes one set pair at a time; input stalls while a finished job waits.
// Reset: synchronous active-low; counters cleared, total_size set to 4096,
// set A storage not cleared.
module subset_indicator_correlation #(
    parameter int MAX_UNIVERSE = 4096
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sic_in_if.sink    i_in,
    sic_out_if.source o_out,
    sic_cfg_if.sink   i_cfg
);
    import sic_pkg::*;

    logic [12:0] r_total;
    logic        job_valid, job_ready;
    t_job        job;

    assign i_cfg.ready = 1'b1;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_total <= 13'd4096;
        else if (i_cfg.valid) r_total <= i_cfg.data;
    end

    sic_merge #(.MAX_UNIVERSE(MAX_UNIVERSE)) u_merge (
        .i_clk, .i_rst_n, .i_in,
        .i_total_size(r_total),
        .o_job_valid(job_valid), .i_job_ready(job_ready), .o_job(job)
    );

    sic_calc u_calc (
        .i_clk, .i_rst_n,
        .i_job_valid(job_valid), .o_job_ready(job_ready), .i_job(job),
        .o_out
    );
endmodule

// ===== rtl/sic_merge.sv =====
// Front end: stores set A, runs the merge pointer for set B, emits jobs.
module sic_merge #(
    parameter int MAX_UNIVERSE = 4096
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sic_in_if.sink          i_in,
    input  logic [12:0]     i_total_size,
    output logic            o_job_valid,
    input  logic            i_job_ready,
    output sic_pkg::t_job   o_job
);
    import sic_pkg::*;

    localparam int AW = $clog2(MAX_UNIVERSE);
    localparam int CW = AW + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;
    localparam logic [1:0] ST_JOB  = 2'd3;

    logic [VAL_W-1:0] r_mem [MAX_UNIVERSE];
    logic [VAL_W-1:0] r_rd;
    logic [1:0]       r_st, n_st;
    logic [CW-1:0]    r_acnt, r_bcnt, r_ptr, r_mcnt;
    logic             r_closed;
    logic [VAL_W-1:0] r_bval;
    logic             r_blast;
    t_job             r_job;
    logic             r_jv;
    logic             acc, wr_en, ptr_ok;
    logic [CW-1:0]    acnt_eff;

    localparam logic [CW-1:0] MAXC = CW'(MAX_UNIVERSE);

    assign i_in.ready  = (r_st == ST_IDLE) && !r_jv;
    assign acc         = i_in.valid && i_in.ready;
    assign acnt_eff    = r_closed ? '0 : r_acnt;
    assign wr_en       = acc && (i_in.data.mode == MODE_A) && (acnt_eff < MAXC);
    assign ptr_ok      = (r_ptr < r_acnt);
    assign o_job_valid = r_jv;
    assign o_job       = r_job;

    // Set A storage, one read port for the merge
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[acnt_eff[AW-1:0]] <= i_in.data.value;
        end
        r_rd <= r_mem[r_ptr[AW-1:0]];
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE: if (acc && i_in.data.mode == MODE_B) n_st = ST_RD;
            ST_RD:   n_st = ST_CMP;
            ST_CMP: begin
                if (ptr_ok && r_rd < r_bval) n_st = ST_RD;
                else if (r_blast) n_st = ST_JOB;
                else n_st = ST_IDLE;
            end
            ST_JOB:  if (!r_jv) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_acnt <= '0; r_bcnt <= '0; r_ptr <= '0;
            r_mcnt <= '0; r_closed <= 1'b0; r_jv <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_jv && i_job_ready) r_jv <= 1'b0;
            if (acc) begin
                if (i_in.data.mode == MODE_A) begin
                    if (r_closed) begin
                        r_bcnt <= '0; r_ptr <= '0; r_mcnt <= '0;
                    end
                    r_acnt   <= (acnt_eff < MAXC) ? acnt_eff + 1'b1 : acnt_eff;
                    r_closed <= i_in.data.last;
                end else begin
                    r_closed <= 1'b1;
                    if (r_bcnt < MAXC) r_bcnt <= r_bcnt + 1'b1;
                end
            end
            if (r_st == ST_CMP) begin
                if (ptr_ok && r_rd < r_bval) begin
                    r_ptr <= r_ptr + 1'b1;
                end else begin
                    if (ptr_ok && r_rd == r_bval) begin
                        r_ptr  <= r_ptr + 1'b1;
                        r_mcnt <= r_mcnt + 1'b1;
                    end
                end
            end
            if (r_st == ST_JOB && !r_jv) begin
                r_jv <= 1'b1;
                r_bcnt <= '0; r_ptr <= '0; r_mcnt <= '0;
            end
        end
    end

    // B element and job payload
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_bval  <= i_in.data.value;
            r_blast <= i_in.data.last;
        end
        if (r_st == ST_JOB && !r_jv) begin
            r_job.nn <= i_total_size;
            r_job.m  <= 17'(r_acnt);
            r_job.n  <= 17'(r_bcnt);
            r_job.c  <= 17'(r_mcnt);
        end
    end

    ap_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= r_acnt) else $error("merge pointer passed set A size");
    ap_match_le_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mcnt <= r_ptr) else $error("match count exceeds pointer");
    ap_job_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_jv) |-> r_bcnt == '0 && r_mcnt == '0) else $error("B state not cleared");
endmodule

// ===== rtl/sic_calc.sv =====
// Back end: computes the Q1.30 correlation by a bitwise square-compare search.
module sic_calc (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    output logic           o_job_ready,
    input  sic_pkg::t_job  i_job,
    sic_out_if.source      o_out
);
    import sic_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_P1   = 3'd1;
    localparam logic [2:0] ST_P2   = 3'd2;
    localparam logic [2:0] ST_SRCH = 3'd3;
    localparam logic [2:0] ST_K2   = 3'd4;
    localparam logic [2:0] ST_KP   = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;
    localparam logic [2:0] ST_CMPQ = 3'd7;

    logic [2:0]   r_st;
    t_job         r_job;
    logic [31:0]  r_ma, r_nb;        // m(N-m), n(N-n)
    logic [63:0]  r_p;
    logic [25:0]  r_d;
    logic         r_neg, r_deg;
    logic [51:0]  r_d2;
    logic [30:0]  r_q;
    logic [5:0]   r_bit;
    logic [30:0]  r_t;
    logic [61:0]  r_k2;
    logic [127:0] r_acc;             // k^2 * p, built from four partial products
    logic [1:0]   r_pp;
    logic         r_ov;
    t_out_item    r_res;
    logic         r_ov_v;
    logic [31:0]  pos, negv;
    logic [30:0]  t_try;
    logic [31:0]  k;
    logic [30:0]  k_part;
    logic [31:0]  p_part;
    logic [63:0]  pp;
    logic [127:0] pp_sh;

    assign o_job_ready  = (r_st == ST_IDLE);
    assign o_out.valid  = r_ov_v;
    assign o_out.data   = r_res;
    assign pos          = 32'(r_job.nn) * 32'(r_job.c);
    assign negv         = 32'(r_job.m) * 32'(r_job.n);
    assign t_try        = r_q | (31'd1 << r_bit[4:0]);
    assign k            = {r_t, 1'b0} - 32'd1;

    // Partial product select: halves of k^2 against halves of p
    assign k_part = r_pp[1] ? r_k2[61:31] : r_k2[30:0];
    assign p_part = r_pp[0] ? r_p[63:32] : r_p[31:0];
    assign pp     = 64'(k_part) * 64'(p_part);

    always_comb begin
        case (r_pp)
            2'd0:    pp_sh = 128'(pp);
            2'd1:    pp_sh = {32'd0, pp, 32'd0};
            2'd2:    pp_sh = {33'd0, pp, 31'd0};
            default: pp_sh = {1'd0, pp, 63'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_ov_v <= 1'b0;
        end else begin
            if (r_ov_v && o_out.ready) r_ov_v <= 1'b0;
            unique case (r_st)
                ST_IDLE: if (i_job_valid) r_st <= ST_P1;
                ST_P1:   r_st <= ST_P2;
                ST_P2:   r_st <= ST_SRCH;
                ST_SRCH: r_st <= (r_bit == 6'd63 || r_deg || r_d == '0) ? ST_OUT : ST_K2;
                ST_K2:   r_st <= ST_KP;
                ST_KP:   r_st <= (r_pp == 2'd3) ? ST_CMPQ : ST_KP;
                ST_CMPQ: r_st <= ST_SRCH;
                ST_OUT:  if (!r_ov_v) begin
                    r_st <= ST_IDLE; r_ov_v <= 1'b1;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    // Datapath: each multiply is registered before the next
    always_ff @(posedge i_clk) begin
        unique case (r_st)
            ST_IDLE: if (i_job_valid) r_job <= i_job;
            ST_P1: begin
                r_deg <= (r_job.m == '0) || (r_job.n == '0) ||
                         (r_job.m >= 17'(r_job.nn)) || (r_job.n >= 17'(r_job.nn));
                r_ma  <= 32'(r_job.m[12:0]) * 32'(r_job.nn - r_job.m[12:0]);
                r_nb  <= 32'(r_job.n[12:0]) * 32'(r_job.nn - r_job.n[12:0]);
                r_neg <= pos < negv;
                r_d   <= (pos >= negv) ? 26'(pos - negv) : 26'(negv - pos);
            end
            ST_P2: begin
                r_p   <= r_ma * r_nb;
                r_d2  <= 52'(r_d) * 52'(r_d);
                r_q   <= '0;
                r_bit <= 6'd30;
            end
            ST_SRCH: begin
                r_t <= t_try;
                r_ov <= (32'(t_try) > 32'h4000_0000);
            end
            ST_K2: begin
                r_k2  <= 62'(k) * 62'(k);
                r_acc <= '0;
                r_pp  <= '0;
            end
            ST_KP: begin
                r_acc <= r_acc + pp_sh;
                r_pp  <= r_pp + 2'd1;
            end
            ST_CMPQ: begin
                // k^2 * p compared against d^2 * 2^62
                if (!r_ov && r_acc <= 128'({r_d2, 62'd0})) r_q <= r_t;
                r_bit <= r_bit - 6'd1;
            end
            ST_OUT: if (!r_ov_v) begin
                r_res.common_count <= r_job.c[12:0];
                r_res.degenerate   <= r_deg;
                r_res.correlation  <= r_deg ? '0 :
                    (r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q}));
            end
            default: ;
        endcase
    end

    ap_res_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov_v && r_res.degenerate |-> r_res.correlation == '0)
        else $error("degenerate result with nonzero correlation");
    ap_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == ST_OUT |-> r_q <= 31'h4000_0000) else $error("ratio above one");
    ap_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_ready |-> r_st == ST_IDLE) else $error("ready outside idle");
endmodule

// ===== test/tb_subset_indicator_correlation.sv =====
// Testbench for the subset indicator correlation block: scoreboard class, drivers, checks.
`timescale 1ns / 1ps

module tb_subset_indicator_correlation;
    import sic_pkg::*;

    localparam int UNIVERSE    = 4096;
    localparam int RANDOM_BEATS = 700;
    localparam int SETTLE_CYC  = 300;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYC    = 600;

    // Scoreboard: tracks the set state and queues predicted results
    class corr_scoreboard;
        logic [12:0]  universe_n;
        logic [12:0]  a_mem [UNIVERSE];
        int unsigned  a_cnt, b_cnt, ptr, hits;
        bit           a_done;
        t_out_item    expq [$];
        int           errors;

        function new();
            universe_n = 13'd4096;
            a_cnt = 0; b_cnt = 0; ptr = 0; hits = 0;
            a_done = 0;
            errors = 0;
        endfunction

        function int pending();
            return expq.size();
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 40) $display("tb mismatch: %s", msg);
        endtask

        function void note_config(logic [12:0] v);
            universe_n = v;
        endfunction

        // round(|d| * 2^30 / sqrt(p)), ties up, capped at 2^30
        function automatic logic [31:0] q30_ratio(logic [63:0] d, logic [63:0] p);
            logic [127:0] rhs, lhs;
            logic [63:0]  q, t, k;
            q = 0;
            if (d == 0) return 32'd0;
            rhs = 128'(d * d) << 62;
            for (int b = 30; b >= 0; b--) begin
                t = q | (64'd1 << b);
                if (t <= (64'd1 << 30)) begin
                    k = 2 * t - 1;
                    lhs = 128'(k * k) * 128'(p);
                    if (lhs <= rhs) q = t;
                end
            end
            return q[31:0];
        endfunction

        function void note_beat(t_in_item it);
            logic [63:0] nn, m, n, c, p, pos, neg;
            t_out_item   r;
            if (it.mode == MODE_A) begin
                if (a_done) begin
                    a_cnt = 0; b_cnt = 0; ptr = 0; hits = 0; a_done = 0;
                end
                if (a_cnt < UNIVERSE) begin
                    a_mem[a_cnt] = it.value;
                    a_cnt++;
                end
                if (it.last) a_done = 1;
                return;
            end
            a_done = 1;
            if (b_cnt < UNIVERSE) b_cnt++;
            while (ptr < a_cnt && a_mem[ptr] < it.value) ptr++;
            if (ptr < a_cnt && a_mem[ptr] == it.value) begin
                hits++;
                ptr++;
            end
            if (!it.last) return;
            nn = universe_n; m = a_cnt; n = b_cnt; c = hits;
            r.common_count = c[12:0];
            r.correlation  = '0;
            r.degenerate   = 1'b0;
            if (m == 0 || n == 0 || m >= nn || n >= nn) begin
                r.degenerate = 1'b1;
            end else begin
                p = m * (nn - m) * n * (nn - n);
                pos = nn * c;
                neg = m * n;
                if (pos >= neg) r.correlation = q30_ratio(pos - neg, p);
                else            r.correlation = -q30_ratio(neg - pos, p);
            end
            expq.push_back(r);
            b_cnt = 0; ptr = 0; hits = 0;
        endfunction

        task check_result(t_out_item got);
            t_out_item want;
            if (expq.size() == 0) begin
                report_mismatch($sformatf("unexpected result corr=%0d cnt=%0d deg=%0b",
                    got.correlation, got.common_count, got.degenerate));
                return;
            end
            want = expq.pop_front();
            if (got.correlation !== want.correlation ||
                got.common_count !== want.common_count ||
                got.degenerate !== want.degenerate)
                report_mismatch($sformatf(
                    "corr %0d/%0d cnt %0d/%0d deg %0b/%0b (got/exp)",
                    got.correlation, want.correlation, got.common_count,
                    want.common_count, got.degenerate, want.degenerate));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    sic_in_if  in_if ();
    sic_out_if out_if ();
    sic_cfg_if cfg_if ();

    subset_indicator_correlation dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    corr_scoreboard sb = new();

    int snd_idle = 18;
    int rcv_idle = 55;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int beats_sent = 0;
    int quiet_cyc = 0;
    logic [12:0] cur_n = 13'd4096;

    // Clock
    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    // Receiver: random stalls plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYC;
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(0, 99) >= rcv_idle);
        end
    end

    // Monitors and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            quiet_cyc++;
            if (in_if.valid && in_if.ready) begin
                sb.note_beat(in_if.data);
                quiet_cyc = 0;
            end
            if (out_if.valid && out_if.ready) begin
                sb.check_result(out_if.data);
                quiet_cyc = 0;
            end
            if (cfg_if.valid && cfg_if.ready) begin
                sb.note_config(cfg_if.data);
                quiet_cyc = 0;
            end
            if (quiet_cyc >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task send_beat(logic mode, logic [12:0] value, logic last);
        t_in_item it;
        while ($urandom_range(0, 99) < snd_idle) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        it.mode = mode; it.value = value; it.last = last;
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        beats_sent++;
    endtask

    // Wait until every predicted result has come, then let the block settle
    task drain();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task write_universe(logic [12:0] v);
        drain();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        cur_n = v;
    endtask

    // Ascending random subset of 1..cur_n with k members
    task send_subset(logic mode, int k);
        int need;
        need = k;
        for (int v = 1; v <= cur_n && need > 0; v++) begin
            if ($urandom_range(0, cur_n - v) < need) begin
                need--;
                send_beat(mode, v[12:0], need == 0);
            end
        end
    endtask

    // Unsorted, out-of-range values with random set ends
    task send_noise(int k);
        for (int i = 0; i < k; i++)
            send_beat(1'($urandom_range(0, 1)), 13'($urandom_range(0, 8191)),
                      $urandom_range(0, 3) == 0);
        send_beat(MODE_B, 13'($urandom_range(0, 8191)), 1'b1);
    endtask

    function int pick_size();
        int hi;
        hi = (cur_n < 16) ? cur_n : 16;
        return $urandom_range(1, hi);
    endfunction

    initial begin
        int nb;
        i_rst_n      <= 1'b0;
        in_if.valid  <= 1'b0;
        in_if.data   <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: B before any A, extremes of value, perfect +/- correlation
        send_beat(MODE_B, 13'd5, 1'b1);
        send_beat(MODE_A, 13'd1, 1'b0);
        send_beat(MODE_A, 13'd2, 1'b0);
        send_beat(MODE_A, 13'd4095, 1'b0);
        send_beat(MODE_A, 13'd4096, 1'b1);
        send_beat(MODE_B, 13'd2, 1'b0);
        send_beat(MODE_B, 13'd4096, 1'b1);
        send_beat(MODE_B, 13'd4095, 1'b1);
        write_universe(13'd1);
        send_beat(MODE_A, 13'd1, 1'b1);
        send_beat(MODE_B, 13'd1, 1'b1);
        write_universe(13'd2);
        send_beat(MODE_A, 13'd1, 1'b1);
        send_beat(MODE_B, 13'd2, 1'b1);
        send_beat(MODE_B, 13'd1, 1'b1);
        write_universe(13'd3);
        send_beat(MODE_A, 13'd1, 1'b0);
        send_beat(MODE_A, 13'd2, 1'b0);
        send_beat(MODE_A, 13'd3, 1'b1);
        send_beat(MODE_B, 13'd3, 1'b1);
        // New pair while the A set is still open: last never set
        send_beat(MODE_A, 13'd2, 1'b0);
        send_beat(MODE_B, 13'd1, 1'b0);
        send_beat(MODE_B, 13'd2, 1'b1);
        write_universe(13'd8191);
        send_beat(MODE_A, 13'd8191, 1'b1);
        send_beat(MODE_B, 13'd8190, 1'b1);

        // Random pairs over three idling phases
        beats_sent = 0;
        while (beats_sent < RANDOM_BEATS) begin
            if (beats_sent < RANDOM_BEATS / 3) begin
                snd_idle = 18; rcv_idle = 55;
            end else if (beats_sent < 2 * RANDOM_BEATS / 3) begin
                snd_idle = 55; rcv_idle = 18;
            end else begin
                snd_idle = 0; rcv_idle = 0;
            end
            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 4))
                    0: write_universe(13'd1);
                    1: write_universe(13'd2);
                    2: write_universe(13'd4096);
                    3: write_universe(13'($urandom_range(3, 40)));
                    default: write_universe(13'($urandom_range(1, 4096)));
                endcase
            end
            if (snd_idle == 0 && hold_token == 0) begin
                hold_token = 1;
                send_subset(MODE_A, pick_size());
                for (int i = 0; i < 12; i++) send_subset(MODE_B, pick_size());
            end else if ($urandom_range(0, 9) == 0) begin
                send_noise($urandom_range(1, 8));
            end else begin
                send_subset(MODE_A, pick_size());
                nb = $urandom_range(1, 3);
                for (int i = 0; i < nb; i++) send_subset(MODE_B, pick_size());
            end
        end

        drain();
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== subset_indicator_correlation.f =====
rtl/sic_pkg.sv
rtl/sic_if.sv
rtl/sic_merge.sv
rtl/sic_calc.sv
rtl/subset_indicator_correlation.sv
test/tb_subset_indicator_correlation.sv
